FILE: rtl/core/rra_pkg.sv
// Shared types and constants of the ring resource arbiter.
package rra_pkg;

  localparam int CoderCount = 8;
  localparam int CoderIdxW  = $clog2(CoderCount);
  localparam int TimeBits   = 32;
  localparam int DlW        = TimeBits + 1;
  localparam int TicketW    = 32;
  localparam int AddrW      = 4;

  typedef logic [CoderIdxW-1:0] cidx_t;

  typedef enum logic [2:0] {
    CMD_ENTER     = 3'd0,
    CMD_LEAVE     = 3'd1,
    CMD_QUERY     = 3'd2,
    CMD_SET_RES   = 3'd3,
    CMD_SET_START = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REG_POLICY   = 2'd0,
    REG_COOLDOWN = 2'd1,
    REG_BURNOUT  = 2'd2
  } reg_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  coder_index;
    logic [2:0]  resource_index;
    logic        resource_free_in;
    logic [31:0] stamp_ms;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        grant;
    logic [31:0] assigned_ticket;
  } rsp_t;

  typedef struct packed {
    logic        policy_mode;
    logic [31:0] cooldown_ms;
    logic [31:0] burnout_ms;
  } cfg_t;

  typedef struct packed {
    logic                waiting;
    logic [TicketW-1:0]  ticket;
    logic [TimeBits-1:0] last_start;
  } coder_ent_t;

  typedef struct packed {
    logic                free;
    logic [TimeBits-1:0] last_release;
  } res_ent_t;

  localparam coder_ent_t CoderEntReset = '{waiting: 1'b0, ticket: '0, last_start: '0};
  localparam res_ent_t   ResEntReset   = '{free: 1'b1, last_release: '0};

endpackage

FILE: rtl/core/ring_resource_arbiter_unit.sv
// Ring resource arbiter: sequencer around the requester and resource memories.
// A new request is taken only after the previous one is written back and its
// result has moved to the output register. Reads are paced by the single read
// port of each memory, one entry a cycle.
// Reset is asynchronous and active low; it clears control state, the valid
// bits of both memories (entries then read as their reset values) and the
// configuration registers.
module ring_resource_arbiter_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rra_pkg::req_t             in_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rra_pkg::rsp_t             out_rsp_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rra_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import rra_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cfg_t   cfg;

  // Latched request and its decoded form.
  req_t   req_q;
  cidx_t  ci, cl, cr, crr, ri;
  logic   ci_ok, ri_ok, is_query, is_coder_cmd;
  logic [2:0] steps_total, step_q;

  // Response pipeline of the memory reads.
  logic       rsp_vld_q;
  logic [2:0] rsp_step_q;

  // Values gathered from the memories. Slot 0 is the left neighbour, slot 1
  // the addressed requester and slot 2 the right neighbour. Resource ready
  // bits hold resources left, own, right and right of right.
  logic [2:0]          cw_q;
  logic [TicketW-1:0]  ct_q  [3];
  logic [DlW-1:0]      cdl_q [3];
  logic [TimeBits-1:0] cls_q;
  logic [3:0]          rdy_q;

  logic [TicketW-1:0] next_ticket_q;
  rsp_t               pend_q;
  logic               out_valid_q;
  rsp_t               out_q;

  // Memory ports.
  logic       c_re, r_re, c_we, r_we;
  cidx_t      c_raddr, r_raddr;
  coder_ent_t c_rdata, c_wdata;
  res_ent_t   r_rdata, r_wdata;

  // Evaluation signals.
  logic [TimeBits-1:0] elapsed;
  logic                arr_ready;
  logic [1:0]          c_slot;
  logic                win_l, win_r, could_l, could_r, take;
  rsp_t                result;
  logic                enter_new;

  rra_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rra_coder_mem u_coder_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata),
    .we_i    (c_we),
    .waddr_i (ci),
    .wdata_i (c_wdata)
  );

  rra_res_mem u_res_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (r_re),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata),
    .we_i    (r_we),
    .waddr_i (ri),
    .wdata_i (r_wdata)
  );

  // Decode of the latched request. Ring neighbours wrap at both ends.
  assign ci    = cidx_t'(req_q.coder_index);
  assign ri    = cidx_t'(req_q.resource_index);
  assign ci_ok = int'(req_q.coder_index) < CoderCount;
  assign ri_ok = int'(req_q.resource_index) < CoderCount;
  assign cl    = (ci == '0) ? cidx_t'(CoderCount - 1) : ci - cidx_t'(1);
  assign cr    = (ci == cidx_t'(CoderCount - 1)) ? '0 : ci + cidx_t'(1);
  assign crr   = (cr == cidx_t'(CoderCount - 1)) ? '0 : cr + cidx_t'(1);

  assign is_query     = ci_ok && (req_q.command == CMD_QUERY);
  assign is_coder_cmd = ci_ok && ((req_q.command == CMD_ENTER) ||
                                  (req_q.command == CMD_LEAVE) ||
                                  (req_q.command == CMD_SET_START));

  // A query reads three requesters and four resources; enter, leave and
  // set_start read back the addressed requester to modify it.
  always_comb begin
    if (is_query) begin
      steps_total = 3'd4;
    end else if (is_coder_cmd) begin
      steps_total = 3'd1;
    end else begin
      steps_total = 3'd0;
    end
  end

  always_comb begin
    c_re    = 1'b0;
    r_re    = 1'b0;
    c_raddr = ci;
    r_raddr = ci;
    if (state_q == ST_READ && step_q < steps_total) begin
      if (is_query) begin
        c_re = step_q < 3'd3;
        r_re = 1'b1;
        case (step_q)
          3'd0: begin
            c_raddr = cl;
            r_raddr = cl;
          end
          3'd1: begin
            c_raddr = ci;
            r_raddr = ci;
          end
          3'd2: begin
            c_raddr = cr;
            r_raddr = cr;
          end
          default: begin
            c_raddr = cr;
            r_raddr = crr;
          end
        endcase
      end else begin
        c_re = 1'b1;
      end
    end
  end

  // A resource is usable when it is free and has rested long enough.
  assign elapsed   = TimeBits'(req_q.now_ms) - r_rdata.last_release;
  assign arr_ready = r_rdata.free && (64'(elapsed) >= 64'(cfg.cooldown_ms));
  assign c_slot    = is_query ? rsp_step_q[1:0] : 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q  <= 1'b0;
      rsp_step_q <= '0;
    end else begin
      rsp_vld_q  <= (state_q == ST_READ) && (step_q < steps_total);
      rsp_step_q <= step_q;
    end
  end

  // Capture read data as it returns; the deadline add is done on arrival so
  // that evaluation only compares.
  always_ff @(posedge clk_i) begin
    if (rsp_vld_q) begin
      if (!is_query || rsp_step_q != 3'd3) begin
        cw_q[c_slot]  <= c_rdata.waiting;
        ct_q[c_slot]  <= c_rdata.ticket;
        cdl_q[c_slot] <= DlW'(c_rdata.last_start) + DlW'(cfg.burnout_ms);
        if (c_slot == 2'd1) begin
          cls_q <= c_rdata.last_start;
        end
      end
      if (is_query) begin
        rdy_q[rsp_step_q[1:0]] <= arr_ready;
      end
    end
  end

  // Priority of the addressed requester over a neighbour: a neighbour that is
  // not waiting always yields; otherwise the earlier deadline wins under EDF,
  // and the lower ticket breaks ties or decides alone under FIFO.
  always_comb begin
    win_l = !cw_q[0];
    win_r = !cw_q[2];
    if (cw_q[0]) begin
      if (cfg.policy_mode && cdl_q[1] != cdl_q[0]) begin
        win_l = cdl_q[1] < cdl_q[0];
      end else begin
        win_l = ct_q[1] < ct_q[0];
      end
    end
    if (cw_q[2]) begin
      if (cfg.policy_mode && cdl_q[1] != cdl_q[2]) begin
        win_r = cdl_q[1] < cdl_q[2];
      end else begin
        win_r = ct_q[1] < ct_q[2];
      end
    end
  end

  assign could_l = cw_q[0] && rdy_q[0] && rdy_q[1];
  assign could_r = cw_q[2] && rdy_q[2] && rdy_q[3];
  assign take    = rdy_q[1] && rdy_q[2] && (win_l || !could_l) && (win_r || !could_r);

  // Write-back and result of the request.
  assign enter_new = !cw_q[1];

  always_comb begin
    c_we    = 1'b0;
    r_we    = 1'b0;
    c_wdata = '{waiting: cw_q[1], ticket: ct_q[1], last_start: cls_q};
    r_wdata = '{free: req_q.resource_free_in,
                last_release: TimeBits'(req_q.stamp_ms)};
    result  = '0;
    if (state_q == ST_EVAL) begin
      if (req_q.command == CMD_SET_RES) begin
        r_we = ri_ok;
      end else if (ci_ok) begin
        case (req_q.command)
          CMD_ENTER: begin
            c_we = enter_new;
            c_wdata.waiting = 1'b1;
            c_wdata.ticket  = next_ticket_q;
            result.assigned_ticket = enter_new ? next_ticket_q : ct_q[1];
          end
          CMD_LEAVE: begin
            c_we = 1'b1;
            c_wdata.waiting = 1'b0;
            c_wdata.ticket  = '0;
          end
          CMD_QUERY: begin
            result.grant           = take;
            result.assigned_ticket = ct_q[1];
          end
          CMD_SET_START: begin
            c_we = 1'b1;
            c_wdata.last_start = TimeBits'(req_q.stamp_ms);
            result.assigned_ticket = ct_q[1];
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer. The result waits in ST_DONE until the output register is free.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (step_q == steps_total) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      step_q        <= '0;
      next_ticket_q <= TicketW'(1);
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_READ) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= '0;
      end
      if (c_we && req_q.command == CMD_ENTER) begin
        next_ticket_q <= next_ticket_q + TicketW'(1);
      end
      if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (state_q == ST_EVAL) begin
      pend_q <= result;
    end
    if (state_q == ST_DONE && (!out_valid_q || out_ready_i)) begin
      out_q <= pend_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: rtl/core/rra_coder_mem.sv
// Requester state memory: one write port, one registered read port.
module rra_coder_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                re_i,
  input  rra_pkg::cidx_t      raddr_i,
  output rra_pkg::coder_ent_t rdata_o,
  input  logic                we_i,
  input  rra_pkg::cidx_t      waddr_i,
  input  rra_pkg::coder_ent_t wdata_i
);
  import rra_pkg::*;

  coder_ent_t             mem_q [CoderCount];
  logic [CoderCount-1:0]  vld_q;
  coder_ent_t             rdata_q;
  logic                   rd_vld_q;

  // Entries never written since reset read as the reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q  <= mem_q[raddr_i];
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rdata_q : CoderEntReset;

endmodule

FILE: rtl/core/rra_res_mem.sv
// Resource state memory: one write port, one registered read port.
module rra_res_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              re_i,
  input  rra_pkg::cidx_t    raddr_i,
  output rra_pkg::res_ent_t rdata_o,
  input  logic              we_i,
  input  rra_pkg::cidx_t    waddr_i,
  input  rra_pkg::res_ent_t wdata_i
);
  import rra_pkg::*;

  res_ent_t               mem_q [CoderCount];
  logic [CoderCount-1:0]  vld_q;
  res_ent_t               rdata_q;
  logic                   rd_vld_q;

  // Entries never written since reset read as free and released at time zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q  <= mem_q[raddr_i];
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rdata_q : ResEntReset;

endmodule

FILE: rtl/core/rra_regs.sv
// APB-style configuration registers of the ring resource arbiter.
module rra_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rra_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output rra_pkg::cfg_t             cfg_o
);
  import rra_pkg::*;

  cfg_t cfg_q;
  logic wr_en;
  reg_e sel;

  assign wr_en  = psel && penable && pwrite;
  assign sel    = reg_e'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (sel)
        REG_POLICY:   cfg_q.policy_mode <= pwdata[0];
        REG_COOLDOWN: cfg_q.cooldown_ms <= pwdata;
        REG_BURNOUT:  cfg_q.burnout_ms  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_POLICY:   prdata = {31'd0, cfg_q.policy_mode};
      REG_COOLDOWN: prdata = cfg_q.cooldown_ms;
      REG_BURNOUT:  prdata = cfg_q.burnout_ms;
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
